### rtl/shfh_pkg.sv
// Shared types and round functions for the streaming SuperFastHash core.
// Holds no parameters and depends on nothing else.
package shfh_pkg;

    // Kind of mixing round that one queued word takes.
    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_ONE,
        KIND_TWO,
        KIND_THREE,
        KIND_FOUR
    } kind_t;

    typedef struct packed {
        logic [31:0] data;
        kind_t       kind;
        logic        fin;
    } entry_t;

    function automatic logic [31:0] sext8(input logic [7:0] b);
        return {{24{b[7]}}, b};
    endfunction

    // One mixing round: the main round for a full word, a tail round, or none for an empty word.
    function automatic logic [31:0] mix_round(input logic [31:0] h_in,
                                              input logic [31:0] w,
                                              input kind_t kind);
        logic [31:0] h;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] t;
        h  = h_in;
        lo = {16'b0, w[15:0]};
        hi = {16'b0, w[31:16]};
        t  = '0;
        case (kind)
            KIND_FOUR: begin
                h = h + lo;
                t = (hi << 11) ^ h;
                h = (h << 16) ^ t;
                h = h + (h >> 11);
            end
            KIND_THREE: begin
                h = h + lo;
                h = h ^ (h << 16);
                h = h ^ (sext8(w[23:16]) << 18);
                h = h + (h >> 11);
            end
            KIND_TWO: begin
                h = h + lo;
                h = h ^ (h << 11);
                h = h + (h >> 17);
            end
            KIND_ONE: begin
                h = h + sext8(w[7:0]);
                h = h ^ (h << 10);
                h = h + (h >> 1);
            end
            default: begin
                h = h_in;
            end
        endcase
        return h;
    endfunction

    // First three steps of the final avalanche.
    function automatic logic [31:0] aval_first(input logic [31:0] h_in);
        logic [31:0] h;
        h = h_in;
        h = h ^ (h << 3);
        h = h + (h >> 5);
        h = h ^ (h << 4);
        return h;
    endfunction

    // Last three steps of the final avalanche.
    function automatic logic [31:0] aval_second(input logic [31:0] h_in);
        logic [31:0] h;
        h = h_in;
        h = h + (h >> 17);
        h = h ^ (h << 25);
        h = h + (h >> 6);
        return h;
    endfunction

endpackage

### rtl/shfh_front.sv
// Input stage: accepts words, saturates the byte count and tags each word
// with its round kind and end-of-message flag. Depends on shfh_pkg.
module shfh_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [31:0]         s_data_word,
    input  logic [2:0]          s_byte_count,
    input  logic                s_last,
    output logic                out_valid,
    input  logic                out_ready,
    output shfh_pkg::entry_t    out_entry
);
    import shfh_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    entry_t entry_reg;
    entry_t entry_next;
    logic   take;

    assign s_ready = !valid_reg || out_ready;
    assign take    = s_valid && s_ready;

    always_comb begin
        entry_next      = entry_reg;
        entry_next.data = s_data_word;
        unique case (s_byte_count)
            3'd0:    entry_next.kind = KIND_NONE;
            3'd1:    entry_next.kind = KIND_ONE;
            3'd2:    entry_next.kind = KIND_TWO;
            3'd3:    entry_next.kind = KIND_THREE;
            default: entry_next.kind = KIND_FOUR;
        endcase
        // A short word always closes the message.
        entry_next.fin = s_last || (entry_next.kind != KIND_FOUR);
    end

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            entry_reg <= entry_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_entry = entry_reg;

endmodule

### rtl/shfh_fifo.sv
// Short queue of classified words between the front and back stages.
// Depends on shfh_pkg for the entry type.
module shfh_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  shfh_pkg::entry_t    push_entry,
    output logic                full,
    input  logic                pop,
    output logic                out_valid,
    output shfh_pkg::entry_t    out_entry
);
    import shfh_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    entry_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign out_valid = (count_reg != '0);
    assign out_entry = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && out_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### rtl/shfh_back.sv
// Back stage: runs the mixing rounds on the running hash, then a two-stage
// avalanche and the result register. Depends on shfh_pkg.
module shfh_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_pop,
    input  shfh_pkg::entry_t    in_entry,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [31:0]         m_hash_value
);
    import shfh_pkg::*;

    logic [31:0] hash_reg;
    logic [31:0] hash_next;
    logic        seen_reg;
    logic        seen_next;
    logic [31:0] mixed;
    logic        mixed_seen;

    logic        a_valid_reg;
    logic        a_valid_next;
    logic [31:0] a_hash_reg;
    logic        a_seen_reg;
    logic        b_valid_reg;
    logic        b_valid_next;
    logic [31:0] b_hash_reg;
    logic        b_seen_reg;
    logic        m_valid_reg;
    logic        m_valid_next;
    logic [31:0] m_hash_reg;

    logic        a_ready;
    logic        b_ready;
    logic        m_free;
    logic        pop_fin;

    assign mixed      = mix_round(hash_reg, in_entry.data, in_entry.kind);
    assign mixed_seen = seen_reg || (in_entry.kind != KIND_NONE);

    assign m_free  = !m_valid_reg || m_ready;
    assign b_ready = !b_valid_reg || m_free;
    assign a_ready = !a_valid_reg || b_ready;

    // Words that do not end a message never wait; the final word waits for
    // room in the avalanche pipeline.
    assign in_pop  = in_valid && (!in_entry.fin || a_ready);
    assign pop_fin = in_pop && in_entry.fin;

    always_comb begin
        hash_next = hash_reg;
        seen_next = seen_reg;
        if (pop_fin) begin
            hash_next = '0;
            seen_next = 1'b0;
        end else if (in_pop) begin
            hash_next = mixed;
            seen_next = mixed_seen;
        end
    end

    always_comb begin
        a_valid_next = a_valid_reg;
        b_valid_next = b_valid_reg;
        m_valid_next = m_valid_reg;
        if (pop_fin) begin
            a_valid_next = 1'b1;
        end else if (b_ready) begin
            a_valid_next = 1'b0;
        end
        if (b_ready) begin
            b_valid_next = a_valid_reg;
        end
        if (m_free) begin
            m_valid_next = b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg    <= '0;
            seen_reg    <= 1'b0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            hash_reg    <= hash_next;
            seen_reg    <= seen_next;
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_fin) begin
            a_hash_reg <= mixed;
            a_seen_reg <= mixed_seen;
        end
        if (b_ready && a_valid_reg) begin
            b_hash_reg <= aval_first(a_hash_reg);
            b_seen_reg <= a_seen_reg;
        end
        if (m_free && b_valid_reg) begin
            m_hash_reg <= b_seen_reg ? aval_second(b_hash_reg) : '0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_hash_value = m_hash_reg;

endmodule

### rtl/superfast_hash_stream_core.sv
// Top level of the streaming SuperFastHash core: front stage, word queue and
// back stage. Depends on shfh_pkg, shfh_front, shfh_fifo and shfh_back.
//
// Each accepted word carries up to four message bytes, first byte in bits
// 7:0, with a byte count (values above four count as four) and a last flag;
// a count below four also ends the message. The core takes one word per
// cycle while the word queue is not full, limited by the combinational
// mixing round on the running hash. The hash appears on the result channel
// once the final word has passed the front register, the queue, the mixing
// register and two avalanche stages; an empty message gives zero. The queue of
// FIFO_DEPTH words lets the input keep flowing while a result waits.
module superfast_hash_stream_core #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_data_word,
    input  logic [2:0]  s_byte_count,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_hash_value
);
    import shfh_pkg::*;

    logic   fr_valid;
    entry_t fr_entry;
    logic   q_full;
    logic   q_valid;
    logic   q_pop;
    entry_t q_entry;

    shfh_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_word  (s_data_word),
        .s_byte_count (s_byte_count),
        .s_last       (s_last),
        .out_valid    (fr_valid),
        .out_ready    (!q_full),
        .out_entry    (fr_entry)
    );

    shfh_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (fr_valid),
        .push_entry (fr_entry),
        .full       (q_full),
        .pop        (q_pop),
        .out_valid  (q_valid),
        .out_entry  (q_entry)
    );

    shfh_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (q_valid),
        .in_pop       (q_pop),
        .in_entry     (q_entry),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

    // A short word must be tagged as the end of its message.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_byte_count < 3'd4))
            |=> (fr_valid && fr_entry.fin))
        else $error("short word not tagged as final");

    // The back stage never pops from an empty queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("pop from empty word queue");

    // A word held in the front stage while the queue is full stays put.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fr_valid && q_full) |=> (fr_valid && $stable(fr_entry)))
        else $error("front word lost while queue full");

endmodule

### tb/superfast_hash_checker.sv
// Checker for the streaming SuperFastHash core: watches both channels, predicts
// each message hash from the accepted words and compares it with the output.
// Stands alone; needs only the core's channel signals.
`timescale 1ns / 1ps

module superfast_hash_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_data_word,
    input  logic [2:0]  s_byte_count,
    input  logic        s_last,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_hash_value,
    output int          mismatch_count,
    output int          pending_count,
    output int          hashes_checked
);

    localparam int FULL_WORD = 4;
    localparam int MAX_REPORTS = 10;

    // Hash of the message in flight, before the final avalanche.
    logic [31:0] partial_hash;
    logic        message_has_bytes;
    logic [31:0] expected_hashes[$];

    function automatic logic [31:0] signed_byte(input logic [7:0] b);
        logic signed [7:0]  narrow;
        logic signed [31:0] wide;
        narrow = b;
        wide = narrow;
        return wide;
    endfunction

    // Folds one word of count bytes into the running hash.
    function automatic logic [31:0] fold_word(input logic [31:0] h_in,
                                              input logic [31:0] w,
                                              input int cnt);
        logic [31:0] h;
        logic [31:0] low_half;
        logic [31:0] high_half;
        logic [31:0] mixed;
        h = h_in;
        low_half = {16'h0000, w[15:0]};
        high_half = {16'h0000, w[31:16]};
        case (cnt)
            4: begin
                h = h + low_half;
                mixed = (high_half << 11) ^ h;
                h = (h << 16) ^ mixed;
                h = h + (h >> 11);
            end
            3: begin
                h = h + low_half;
                h = h ^ (h << 16);
                h = h ^ (signed_byte(w[23:16]) << 18);
                h = h + (h >> 11);
            end
            2: begin
                h = h + low_half;
                h = h ^ (h << 11);
                h = h + (h >> 17);
            end
            1: begin
                h = h + signed_byte(w[7:0]);
                h = h ^ (h << 10);
                h = h + (h >> 1);
            end
            default: begin
            end
        endcase
        return h;
    endfunction

    function automatic logic [31:0] avalanche_hash(input logic [31:0] h_in);
        logic [31:0] h;
        h = h_in;
        h = h ^ (h << 3);
        h = h + (h >> 5);
        h = h ^ (h << 4);
        h = h + (h >> 17);
        h = h ^ (h << 25);
        h = h + (h >> 6);
        return h;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] expected_value,
                                   input logic [31:0] actual_value);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] %s: expected %08h, got %08h", $realtime, what,
                     expected_value, actual_value);
        end
    endtask

    initial begin
        partial_hash = '0;
        message_has_bytes = 1'b0;
        mismatch_count = 0;
        pending_count = 0;
        hashes_checked = 0;
    end

    always @(posedge aclk) begin
        int          cnt;
        logic        ends_message;
        logic [31:0] next_hash;
        if (!aresetn) begin
            partial_hash = '0;
            message_has_bytes = 1'b0;
        end else begin
            // A result never belongs to a word accepted at the same edge.
            if (m_valid && m_ready) begin
                if (expected_hashes.size() == 0) begin
                    report_mismatch("hash with no message pending", 32'h0, m_hash_value);
                end else begin
                    if (m_hash_value !== expected_hashes[0]) begin
                        report_mismatch("hash_value", expected_hashes[0], m_hash_value);
                    end
                    void'(expected_hashes.pop_front());
                    hashes_checked++;
                end
            end
            if (s_valid && s_ready) begin
                cnt = (s_byte_count > FULL_WORD) ? FULL_WORD : int'(s_byte_count);
                ends_message = s_last || (cnt < FULL_WORD);
                next_hash = fold_word(partial_hash, s_data_word, cnt);
                if (cnt != 0) begin
                    message_has_bytes = 1'b1;
                end
                if (ends_message) begin
                    expected_hashes.push_back(message_has_bytes ?
                                              avalanche_hash(next_hash) : 32'h0);
                    partial_hash = '0;
                    message_has_bytes = 1'b0;
                end else begin
                    partial_hash = next_hash;
                end
            end
        end
        pending_count = expected_hashes.size();
    end

endmodule

### tb/tb_superfast_hash_stream_core.sv
// Testbench top for the streaming SuperFastHash core: drives directed and random
// messages with random idling on both channels and gives the verdict.
// Depends on superfast_hash_stream_core and superfast_hash_checker.
`timescale 1ns / 1ps

module tb_superfast_hash_stream_core;

    localparam int RANDOM_WORDS = 1250;
    localparam int LONG_HOLD_AT = 400;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES = 12;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_data_word;
    logic [2:0]  s_byte_count;
    logic        s_last;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_hash_value;

    int mismatch_count;
    int pending_count;
    int hashes_checked;
    int words_sent;
    int messages_sent;
    logic quiet_sender;

    superfast_hash_stream_core u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_word (s_data_word),
        .s_byte_count(s_byte_count),
        .s_last      (s_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hash_value(m_hash_value)
    );

    superfast_hash_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_word   (s_data_word),
        .s_byte_count  (s_byte_count),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hash_value  (m_hash_value),
        .mismatch_count(mismatch_count),
        .pending_count (pending_count),
        .hashes_checked(hashes_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int idle_length();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    task automatic send_word(input logic [31:0] data, input logic [2:0] cnt,
                             input logic fin);
        int gap;
        gap = 0;
        if (!quiet_sender && $urandom_range(0, 3) == 0) begin
            gap = idle_length();
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            s_data_word <= $urandom();
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_word <= data;
        s_byte_count <= cnt;
        s_last <= fin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
        if (fin || cnt < 3'd4) begin
            messages_sent++;
        end
    endtask

    // One message with random content: full words, then a final word that is
    // either short or full with the last flag set.
    task automatic send_random_message();
        int body_words;
        body_words = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40)
                                                  : $urandom_range(0, 6);
        quiet_sender = ($urandom_range(0, 3) == 0);
        repeat (body_words) begin
            send_word($urandom(), 3'($urandom_range(4, 7)), 1'b0);
        end
        if ($urandom_range(0, 2) == 0) begin
            send_word($urandom(), 3'($urandom_range(4, 7)), 1'b1);
        end else begin
            send_word($urandom(), 3'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data_word = '0;
        s_byte_count = '0;
        s_last = 1'b0;
        words_sent = 0;
        messages_sent = 0;
        quiet_sender = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty messages, with and without the last flag.
        send_word(32'hDEADBEEF, 3'd0, 1'b1);
        send_word(32'h12345678, 3'd0, 1'b0);
        // Tails of one, two and three bytes, on both sides of the sign bit.
        send_word(32'hFFFFFF80, 3'd1, 1'b1);
        send_word(32'h0000007F, 3'd1, 1'b0);
        send_word(32'hFFFFFFFF, 3'd1, 1'b1);
        send_word(32'hFFFFFFFF, 3'd2, 1'b1);
        send_word(32'h00800000, 3'd3, 1'b1);
        send_word(32'hFF7FFFFF, 3'd3, 1'b0);
        // Full final words at the extremes.
        send_word(32'hFFFFFFFF, 3'd4, 1'b1);
        send_word(32'h00000000, 3'd4, 1'b1);
        // Counts above four act as full words.
        send_word(32'hFFFFFFFF, 3'd4, 1'b0);
        send_word(32'h12345678, 3'd5, 1'b0);
        send_word(32'h80000080, 3'd6, 1'b0);
        send_word(32'hFFFFFFFF, 3'd7, 1'b1);
        // Full words closed by an empty tail, and longer mixed messages.
        send_word(32'hA5A5A5A5, 3'd4, 1'b0);
        send_word(32'h5A5A5A5A, 3'd0, 1'b1);
        send_word(32'h00000000, 3'd5, 1'b0);
        send_word(32'hFFFFFFFF, 3'd1, 1'b1);
        send_word(32'h7FFF8000, 3'd7, 1'b0);
        send_word(32'hFFFFFFFF, 3'd3, 1'b1);
        send_word(32'h00000000, 3'd6, 1'b0);
        send_word(32'hFFFF0000, 3'd2, 1'b0);

        while (words_sent < RANDOM_WORDS) begin
            send_random_message();
        end
        s_valid <= 1'b0;

        @(negedge aclk);
        while (pending_count != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Hashed %0d messages from %0d words; %0d hashes compared, %0d mismatched.",
                 messages_sent, words_sent, hashes_checked, mismatch_count);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // The receiver stalls on its own schedule, with calm stretches and one long
    // hold that backs the core up into its input.
    initial begin
        int ready_cycle;
        int ready_hold;
        m_ready = 1'b0;
        ready_cycle = 0;
        ready_hold = 0;
        forever begin
            @(posedge aclk);
            ready_cycle++;
            if (ready_cycle == LONG_HOLD_AT) begin
                ready_hold = LONG_HOLD_CYCLES;
            end else if (ready_hold > 0) begin
                ready_hold--;
            end else if ((ready_cycle / 300) % 3 != 2 && $urandom_range(0, 4) == 0) begin
                ready_hold = idle_length();
            end
            m_ready <= (ready_hold == 0);
        end
    end

    initial begin
        #2_000_000;
        $display("Run timed out with %0d hashes still outstanding.", pending_count);
        $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
rtl/shfh_pkg.sv
rtl/shfh_front.sv
rtl/shfh_fifo.sv
rtl/shfh_back.sv
rtl/superfast_hash_stream_core.sv
tb/superfast_hash_checker.sv
tb/tb_superfast_hash_stream_core.sv
